// File: src/pll_partial_tracker_assert.svh
// assertion macros for the pll partial tracker
`ifndef PLL_PARTIAL_TRACKER_ASSERT_SVH
`define PLL_PARTIAL_TRACKER_ASSERT_SVH

// same-cycle implication on clk, off while rst is high
`define PLLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst is high
`define PLLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pllt_pkg.sv
// shared types, constants and the quarter-wave sine table of the pll partial tracker
package pllt_pkg;

  // sizes
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int SAMPLE_BITS      = 24;
  localparam int SAMPLE_DOWN      = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  localparam int SAMPLE_UP        = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
  localparam int APB_ADDR_BITS    = 5;
  localparam int APB_DATA_BITS    = 32;

  // fixed-point constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [22:0] Q23_MAX     = 23'h7FFFFF;
  localparam logic [16:0] GATE_OPEN   = 17'd65536;
  localparam logic [17:0] ENV_COEF    = 18'd167772;
  localparam logic [13:0] GATE_COEF   = 14'd8389;

  // register reset values
  localparam logic [30:0] INIT_INC_RESET   = 31'd19685267;
  localparam logic [30:0] MIN_INC_RESET    = 31'd19403050;
  localparam logic [30:0] MAX_INC_RESET    = 31'd19971594;
  localparam logic [23:0] PHASE_GAIN_RESET = 24'd341799;
  localparam logic [23:0] FREQ_GAIN_RESET  = 24'd6836;
  localparam logic [22:0] GATE_ON_RESET    = 23'd1677722;
  localparam logic [22:0] GATE_OFF_RESET   = 23'd419430;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [23:0] q23_t;
  typedef logic [SINE_TABLE_DEPTH-1:0][22:0] sine_rom_t;

  // register map, byte address is four times the index
  typedef enum logic [2:0] {
    REG_INIT_INC,
    REG_MIN_INC,
    REG_MAX_INC,
    REG_PHASE_GAIN,
    REG_FREQ_GAIN,
    REG_GATE_ON,
    REG_GATE_OFF
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] init_increment;
    logic [30:0] min_increment;
    logic [30:0] max_increment;
    logic [23:0] phase_gain;
    logic [23:0] freq_gain;
    logic [22:0] gate_on_level;
    logic [22:0] gate_off_level;
  } cfg_t;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_X_SIN,
    MUL_X_COS,
    MUL_FG_ERR,
    MUL_PG_ERR,
    MUL_ENV_STEP,
    MUL_GATE_STEP,
    MUL_ENV_GATE,
    MUL_EG_SIN
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN,
    ST_COS,
    ST_ERR,
    ST_DEM,
    ST_INC,
    ST_PHASE,
    ST_ENV,
    ST_TGT,
    ST_GMUL,
    ST_GATE,
    ST_EGMUL,
    ST_DMUL,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     load_sample;
    logic     rom_cos;
    logic     take_sin;
    logic     take_cos;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_err;
    logic     upd_dem;
    logic     upd_inc;
    logic     upd_phase;
    logic     upd_env;
    logic     upd_tgt;
    logic     upd_gate;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // taylor term divisors (2k)(2k+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
    logic [63:0] q;
    case (k)
      1:       q = t / 64'd6;
      2:       q = t / 64'd20;
      3:       q = t / 64'd42;
      4:       q = t / 64'd72;
      5:       q = t / 64'd110;
      default: q = t / 64'd156;
    endcase
    return q;
  endfunction

  // quarter-wave table, round(sin(pi/2 * j / depth) * 2^23) by integer series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 6; k++) begin
        term = taylor_div((term * x2) >> 30, k);
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      sum = (sum + 64'sd64) >>> 7;
      if (sum > $signed({41'd0, Q23_MAX})) begin
        sum = $signed({41'd0, Q23_MAX});
      end
      rom[i] = sum[22:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // bring a raw sample to q1.23
  function automatic q23_t scale_sample(input sample_t raw);
    logic signed [63:0] v;
    v = 64'(raw);
    v = (v >>> SAMPLE_DOWN) <<< SAMPLE_UP;
    return v[23:0];
  endfunction

endpackage

// File: src/pllt_sample_if.sv
// sample channel: valid, ready and one audio sample
interface pllt_sample_if;
  import pllt_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: src/pllt_result_if.sv
// result channel: valid, ready and the tracker outputs
interface pllt_result_if;
  import pllt_pkg::*;

  logic        valid;
  logic        ready;
  q23_t        drive;
  q23_t        ref_sine;
  logic [22:0] amplitude;
  logic [16:0] gate_level;

  modport source (output valid, output drive, output ref_sine, output amplitude,
                  output gate_level, input ready);
  modport sink (input valid, input drive, input ref_sine, input amplitude,
                input gate_level, output ready);
endinterface

// File: src/pll_partial_tracker.sv
// pll_partial_tracker top level: one phase-locked sine tracker for a stream of
// audio samples. Each accepted sample gives one result (drive, reference sine,
// amplitude envelope, smoothed gate). The sequencer steps a sample through the
// states sin, cos, err, dem, inc, phase, env, tgt, gmul, gate, egmul, dmul and
// out, and waits in out while the previous result still waits to be taken. The
// pace is set by the one shared 25 x 25 multiplier, which carries the eight
// dependent products of a sample in turn, and by the single read port of the
// 1024-entry quarter-wave sine rom, read once for the sine and once for the
// cosine. A new sample is taken as soon as the sequencer is back in idle, even
// while the last result is still held. The rom is constant, so there is no
// clearing pass after reset. Writing the start increment register also reloads
// the running increment; configuration must be written only while no sample is
// in flight, which the block itself does not enforce.
`include "pll_partial_tracker_assert.svh"

module pll_partial_tracker (
  input  logic                               clk,
  input  logic                               rst,
  pllt_sample_if.sink                        sample_ch,
  pllt_result_if.source                      result_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pllt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [pllt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [pllt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import pllt_pkg::*;

  cfg_t       cfg;
  logic       init_load;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  pllt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .init_load (init_load)
  );

  // sequencer
  pllt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  pllt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch.sample),
    .cfg       (cfg),
    .init_load (init_load),
    .cmd       (cmd),
    .status    (status),
    .result_ch (result_ch)
  );

  // checks
  `PLLT_ASSERT_NEXT(a_busy_after_accept, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "sample request taken while a sample is in flight")
  `PLLT_ASSERT_SAME(a_load_matches_accept, cmd.load_sample, sample_ch.valid && sample_ch.ready, "sample loaded without a handshake")
  `PLLT_ASSERT_SAME(a_result_slot_free, cmd.load_out, !result_ch.valid || result_ch.ready, "result overwritten before it was taken")
  `PLLT_ASSERT_SAME(a_gate_in_range, result_ch.valid, result_ch.gate_level <= GATE_OPEN, "gate level beyond fully open")
endmodule

// File: src/pllt_regs.sv
// apb configuration registers of the pll partial tracker
module pllt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pllt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [pllt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [pllt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output pllt_pkg::cfg_t                     cfg,
  output logic                               init_load
);
  import pllt_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_increment <= INIT_INC_RESET;
      cfg.min_increment  <= MIN_INC_RESET;
      cfg.max_increment  <= MAX_INC_RESET;
      cfg.phase_gain     <= PHASE_GAIN_RESET;
      cfg.freq_gain      <= FREQ_GAIN_RESET;
      cfg.gate_on_level  <= GATE_ON_RESET;
      cfg.gate_off_level <= GATE_OFF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_INIT_INC:   cfg.init_increment <= pwdata[30:0];
        REG_MIN_INC:    cfg.min_increment  <= pwdata[30:0];
        REG_MAX_INC:    cfg.max_increment  <= pwdata[30:0];
        REG_PHASE_GAIN: cfg.phase_gain     <= pwdata[23:0];
        REG_FREQ_GAIN:  cfg.freq_gain      <= pwdata[23:0];
        REG_GATE_ON:    cfg.gate_on_level  <= pwdata[22:0];
        REG_GATE_OFF:   cfg.gate_off_level <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // a start increment write reloads the running increment next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      init_load <= 1'b0;
    end else begin
      init_load <= wr_en && (idx == REG_INIT_INC);
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_INIT_INC:   prdata = APB_DATA_BITS'(cfg.init_increment);
      REG_MIN_INC:    prdata = APB_DATA_BITS'(cfg.min_increment);
      REG_MAX_INC:    prdata = APB_DATA_BITS'(cfg.max_increment);
      REG_PHASE_GAIN: prdata = APB_DATA_BITS'(cfg.phase_gain);
      REG_FREQ_GAIN:  prdata = APB_DATA_BITS'(cfg.freq_gain);
      REG_GATE_ON:    prdata = APB_DATA_BITS'(cfg.gate_on_level);
      REG_GATE_OFF:   prdata = APB_DATA_BITS'(cfg.gate_off_level);
      default:        prdata = '0;
    endcase
  end
endmodule

// File: src/pllt_ctrl.sv
// sequencer that steps one sample through the shared multiplier
module pllt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pllt_pkg::dp_status_t status,
  output pllt_pkg::dp_cmd_t    cmd
);
  import pllt_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SIN;
      ST_SIN:   state_next = ST_COS;
      ST_COS:   state_next = ST_ERR;
      ST_ERR:   state_next = ST_DEM;
      ST_DEM:   state_next = ST_INC;
      ST_INC:   state_next = ST_PHASE;
      ST_PHASE: state_next = ST_ENV;
      ST_ENV:   state_next = ST_TGT;
      ST_TGT:   state_next = ST_GMUL;
      ST_GMUL:  state_next = ST_GATE;
      ST_GATE:  state_next = ST_EGMUL;
      ST_EGMUL: state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_OUT;
      ST_OUT:   if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // commands, no request taken while in reset
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = !rst;
        cmd.load_sample = in_valid && !rst;
      end
      ST_SIN: begin
        cmd.take_sin = 1'b1;
        cmd.rom_cos  = 1'b1;
      end
      ST_COS: begin
        cmd.take_cos = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_X_SIN;
      end
      ST_ERR: begin
        cmd.upd_err = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X_COS;
      end
      ST_DEM: begin
        cmd.upd_dem = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FG_ERR;
      end
      ST_INC: begin
        cmd.upd_inc = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PG_ERR;
      end
      ST_PHASE: begin
        cmd.upd_phase = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_ENV_STEP;
      end
      ST_ENV:  cmd.upd_env = 1'b1;
      ST_TGT:  cmd.upd_tgt = 1'b1;
      ST_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GATE_STEP;
      end
      ST_GATE: cmd.upd_gate = 1'b1;
      ST_EGMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV_GATE;
      end
      ST_DMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EG_SIN;
      end
      ST_OUT:  cmd.load_out = status.out_free;
      default: ;
    endcase
  end
endmodule

// File: src/pllt_dp.sv
// datapath: sine rom, shared multiplier, tracker state and result register
module pllt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pllt_pkg::sample_t    sample,
  input  pllt_pkg::cfg_t       cfg,
  input  logic                 init_load,
  input  pllt_pkg::dp_cmd_t    cmd,
  output pllt_pkg::dp_status_t status,
  pllt_result_if.source        result_ch
);
  import pllt_pkg::*;

  // tracker state
  logic [31:0] phase_acc;
  logic [30:0] increment;
  logic [22:0] envelope;
  logic [16:0] gate;

  // per-sample working registers
  q23_t        x;
  q23_t        s;
  q23_t        c;
  q23_t        err;
  logic        d_neg;
  logic [22:0] d_mag;
  logic        g_neg;
  logic [16:0] g_mag;

  // rom read
  logic [1:0]                rd_quad;
  logic [29:0]               rd_frac;
  logic [29:0]               rd_mirror;
  logic [SINE_ADDR_BITS-1:0] rd_idx;
  logic                      rd_full;
  logic [22:0]               rom_data;
  logic                      rom_full;
  logic                      rom_neg;
  logic [22:0]               sine_mag;
  q23_t                      sine_val;

  // multiplier
  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [49:0] prod;
  logic signed [26:0] prod_q23;
  logic signed [26:0] neg_q23;

  // update terms
  logic signed [24:0] dem;
  logic [23:0]        dem_abs;
  logic signed [24:0] dem_diff;
  logic signed [33:0] inc_sum;
  logic [30:0]        inc_next;
  logic [23:0]        env_step;
  logic signed [24:0] env_sum;
  logic [22:0]        env_next;
  logic [16:0]        target;
  logic signed [17:0] gate_diff;
  logic [16:0]        gate_step;
  logic [16:0]        gate_next;

  // result register
  logic        out_valid;
  q23_t        out_drive;
  q23_t        out_sine;
  logic [22:0] out_amp;
  logic [16:0] out_gate;

  // quarter-wave address: odd quarters mirror, top of the mirror is full scale
  always_comb begin
    rd_quad   = phase_acc[31:30] + {1'b0, cmd.rom_cos};
    rd_frac   = phase_acc[29:0];
    rd_mirror = 30'd0 - rd_frac;
    rd_full   = rd_quad[0] && (rd_frac == 30'd0);
    rd_idx    = rd_quad[0] ? rd_mirror[29 -: SINE_ADDR_BITS]
                           : rd_frac[29 -: SINE_ADDR_BITS];
  end

  always_ff @(posedge clk) begin
    rom_data <= SINE_ROM[rd_idx];
    rom_full <= rd_full;
    rom_neg  <= rd_quad[1];
  end

  // lower half negates
  always_comb begin
    sine_mag = rom_full ? Q23_MAX : rom_data;
    sine_val = rom_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_X_SIN: begin
        mul_a = 25'(x);
        mul_b = 25'(s);
      end
      MUL_X_COS: begin
        mul_a = 25'(x);
        mul_b = 25'(c);
      end
      MUL_FG_ERR: begin
        mul_a = $signed({1'b0, cfg.freq_gain});
        mul_b = 25'(err);
      end
      MUL_PG_ERR: begin
        mul_a = $signed({1'b0, cfg.phase_gain});
        mul_b = 25'(err);
      end
      MUL_ENV_STEP: begin
        mul_a = $signed({2'b0, d_mag});
        mul_b = $signed({7'b0, ENV_COEF});
      end
      MUL_GATE_STEP: begin
        mul_a = $signed({8'b0, g_mag});
        mul_b = $signed({11'b0, GATE_COEF});
      end
      MUL_ENV_GATE: begin
        mul_a = $signed({2'b0, envelope});
        mul_b = $signed({8'b0, gate});
      end
      MUL_EG_SIN: begin
        mul_a = $signed({2'b0, prod[38:16]});
        mul_b = 25'(s);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // product scaled back to q1.23, floor
  assign prod_q23 = prod[49:23];
  assign neg_q23  = -prod_q23;

  // demodulated magnitude against the envelope
  always_comb begin
    dem      = $signed(prod[47:23]);
    dem_abs  = dem[24] ? 24'(-dem) : 24'(dem);
    dem_diff = $signed({1'b0, dem_abs}) - $signed({2'b0, envelope});
  end

  // increment with clamp, lower bound checked first
  always_comb begin
    inc_sum = $signed({3'b0, increment}) + 34'(prod_q23);
    if (inc_sum < $signed({3'b0, cfg.min_increment})) begin
      inc_next = cfg.min_increment;
    end else if (inc_sum > $signed({3'b0, cfg.max_increment})) begin
      inc_next = cfg.max_increment;
    end else begin
      inc_next = inc_sum[30:0];
    end
  end

  // envelope step, magnitude rounded up, held in range
  always_comb begin
    env_step = prod[47:24] + {23'b0, |prod[23:0]};
    env_sum  = d_neg ? $signed({2'b0, envelope}) - $signed({1'b0, env_step})
                     : $signed({2'b0, envelope}) + $signed({1'b0, env_step});
    if (env_sum < 0) begin
      env_next = '0;
    end else if (env_sum > $signed({2'b0, Q23_MAX})) begin
      env_next = Q23_MAX;
    end else begin
      env_next = env_sum[22:0];
    end
  end

  // hysteresis target, open test first
  always_comb begin
    if (envelope > cfg.gate_on_level) begin
      target = GATE_OPEN;
    end else if (envelope < cfg.gate_off_level) begin
      target = '0;
    end else begin
      target = gate;
    end
    gate_diff = $signed({1'b0, target}) - $signed({1'b0, gate});
  end

  // gate step, magnitude rounded up
  always_comb begin
    gate_step = prod[40:24] + {16'b0, |prod[23:0]};
    gate_next = g_neg ? gate - gate_step : gate + gate_step;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      x <= scale_sample(sample);
    end
    if (cmd.take_sin) begin
      s <= sine_val;
    end
    if (cmd.take_cos) begin
      c <= sine_val;
    end
    if (cmd.upd_err) begin
      err <= neg_q23[23:0];
    end
    if (cmd.upd_dem) begin
      d_neg <= dem_diff[24];
      d_mag <= dem_diff[24] ? 23'(-dem_diff) : 23'(dem_diff);
    end
    if (cmd.upd_tgt) begin
      g_neg <= gate_diff[17];
      g_mag <= gate_diff[17] ? 17'(-gate_diff) : 17'(gate_diff);
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      increment <= INIT_INC_RESET;
      envelope  <= '0;
      gate      <= '0;
    end else begin
      if (init_load) begin
        increment <= cfg.init_increment;
      end else if (cmd.upd_inc) begin
        increment <= inc_next;
      end
      if (cmd.upd_phase) begin
        phase_acc <= phase_acc + {1'b0, increment} + 32'(prod_q23);
      end
      if (cmd.upd_env) begin
        envelope <= env_next;
      end
      if (cmd.upd_gate) begin
        gate <= gate_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_drive <= prod[46:23];
      out_sine  <= s;
      out_amp   <= envelope;
      out_gate  <= gate;
    end
  end

  assign status.out_free      = !out_valid || result_ch.ready;
  assign result_ch.valid      = out_valid;
  assign result_ch.drive      = out_drive;
  assign result_ch.ref_sine   = out_sine;
  assign result_ch.amplitude  = out_amp;
  assign result_ch.gate_level = out_gate;
endmodule
